>>> hdl/ttsip_pkg.sv
// Shared types, constants and helpers for the text-to-signed-integer parser.
// No dependencies; used by ttsip_ctrl, ttsip_dp and the top level.
package ttsip_pkg;

    localparam int MAX_CHARS_DEF = 4096;
    localparam int POS_LIMIT     = 8191;
    localparam int POS_W         = 13;
    localparam int ACC_W         = 64;
    localparam int BASE_W        = 6;
    localparam int PROD_W        = ACC_W + BASE_W;

    localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [BASE_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_MIN    = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [BASE_W-1:0] DIGIT_NONE  = 6'd36;

    localparam logic [ACC_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] DIGIT_OFS = 8'd10;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_BAD_BASE = 2'd2
    } t_status;

    // Controller -> datapath
    typedef struct packed {
        logic capture;     // take the input beat into the datapath
        logic clear;       // new string: drop all string state
        logic load_radix;
        logic set_neg;
        logic set_b10;
        logic set_b8;
        logic set_b16;
        logic mark_zero;   // leading '0' counted as a digit
        logic take;        // accumulate this digit
        logic finish;      // emit the converted value
        logic bad_base;    // emit the invalid-base result
        logic advance;     // bump the character position
    } t_dp_cmd;

    // Datapath -> controller, decoded from the captured beat and datapath state
    typedef struct packed {
        logic first;
        logic blank;
        logic sign;
        logic minus;
        logic zero_char;
        logic x_char;
        logic radix_bad;
        logic base0;
        logic base16;
        logic lt_base;
        logic lt8;
        logic lt10;
        logic out_full;
    } t_dp_status;

    function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
        logic [BASE_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_0 && c <= CH_9) begin
            d = BASE_W'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = BASE_W'(c - CH_LA + DIGIT_OFS);
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = BASE_W'(c - CH_UA + DIGIT_OFS);
        end
        return d;
    endfunction

endpackage

>>> hdl/ttsip_ctrl.sv
// Parser controller: input handshake, two-step sequencing and the parse phase.
// Depends on ttsip_pkg; drives ttsip_dp through t_dp_cmd.
module ttsip_ctrl import ttsip_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_TAKE = 2'b01,
        S_EXEC = 2'b10
    } t_step;

    typedef enum logic [5:0] {
        P_IDLE   = 6'b000001,
        P_LEAD   = 6'b000010,
        P_SIGNED = 6'b000100,
        P_ZERO   = 6'b001000,
        P_PREFIX = 6'b010000,
        P_DIGITS = 6'b100000
    } t_phase;

    t_step   r_step, n_step;
    t_phase  r_phase, n_phase;
    t_dp_cmd raw;
    logic    go;
    logic    use8;
    logic    use10;
    logic    commit;

    // Walk the phases for the captured byte; phases fall through as in a parser
    always_comb begin
        raw     = '0;
        n_phase = r_phase;
        go      = 1'b1;
        use8    = 1'b0;
        use10   = 1'b0;
        if (i_st.first) begin
            raw.clear = 1'b1;
            if (i_st.radix_bad) begin
                raw.bad_base = 1'b1;
                n_phase      = P_IDLE;
                go           = 1'b0;
            end else begin
                raw.load_radix = 1'b1;
                n_phase        = P_LEAD;
            end
        end else if (r_phase == P_IDLE) begin
            go = 1'b0;
        end
        raw.advance = go;

        if (go && n_phase == P_LEAD) begin
            if (i_st.blank) begin
                go = 1'b0;
            end else if (i_st.sign) begin
                raw.set_neg = i_st.minus;
                n_phase     = P_SIGNED;
                go          = 1'b0;
            end else begin
                n_phase = P_SIGNED;
            end
        end

        if (go) begin
            case (n_phase)
                P_SIGNED: begin
                    if (i_st.zero_char && (i_st.base0 || i_st.base16)) begin
                        raw.mark_zero = 1'b1;
                        n_phase       = P_ZERO;
                        go            = 1'b0;
                    end else begin
                        if (i_st.base0) begin
                            raw.set_b10 = 1'b1;
                            use10       = 1'b1;
                        end
                        n_phase = P_DIGITS;
                    end
                end
                P_ZERO: begin
                    if (i_st.x_char) begin
                        raw.set_b16 = 1'b1;
                        n_phase     = P_PREFIX;
                        go          = 1'b0;
                    end else begin
                        if (i_st.base0) begin
                            raw.set_b8 = 1'b1;
                            use8       = 1'b1;
                        end
                        n_phase = P_DIGITS;
                    end
                end
                P_PREFIX: n_phase = P_DIGITS;
                default: ;
            endcase
        end

        if (go) begin
            if (use10 ? i_st.lt10 : (use8 ? i_st.lt8 : i_st.lt_base)) begin
                raw.take = 1'b1;
            end else begin
                raw.finish = 1'b1;
                n_phase    = P_IDLE;
            end
        end
    end

    // A step that emits waits while the result register is still held
    assign commit = (r_step == S_EXEC) && !((raw.finish || raw.bad_base) && i_st.out_full);

    always_comb begin
        o_cmd         = commit ? raw : '0;
        o_cmd.capture = (r_step == S_TAKE) && i_in_valid;
    end

    assign o_in_stall = (r_step != S_TAKE);

    always_comb begin
        n_step = r_step;
        case (r_step)
            S_TAKE:  if (i_in_valid) n_step = S_EXEC;
            S_EXEC:  if (commit)     n_step = S_TAKE;
            default: n_step = S_TAKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= S_TAKE;
            r_phase <= P_IDLE;
        end else begin
            r_step <= n_step;
            if (commit) begin
                r_phase <= n_phase;
            end
        end
    end

endmodule

>>> hdl/ttsip_dp.sv
// Parser datapath: radix register, byte capture, base multiplier, limit check,
// string state and result register. Depends on ttsip_pkg.
module ttsip_dp import ttsip_pkg::*; #(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [BASE_W-1:0]       i_cfg_wr_data,
    input  logic                    i_first_char,
    input  logic [7:0]              i_char_code,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_st,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic signed [ACC_W-1:0] o_value,
    output logic [1:0]              o_status,
    output logic [POS_W-1:0]        o_end_offset
);

    localparam logic [POS_W-1:0] POS_CAP =
        POS_W'((MAX_CHARS > POS_LIMIT) ? POS_LIMIT : MAX_CHARS);
    localparam logic [PROD_W-1:0] LIM_POS = PROD_W'(VALUE_MAX);
    localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(VALUE_MIN);

    logic [BASE_W-1:0] r_radix;
    logic              r_first;
    logic [7:0]        r_char;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg, n_neg;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [BASE_W-1:0] r_base, n_base;
    logic              r_saw, n_saw;
    logic              r_ovf, n_ovf;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_dend, n_dend;
    logic              r_ovalid;
    logic [ACC_W-1:0]  r_value, n_value;
    t_status           r_status, n_status;
    logic [POS_W-1:0]  r_end, n_end;

    logic [BASE_W-1:0] cur_base;
    logic [BASE_W-1:0] base_m;
    logic [BASE_W-1:0] dig;
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] prod_use;
    logic [PROD_W-1:0] sum;
    logic              hit;
    logic              c_neg, c_saw, c_ovf;
    logic [ACC_W-1:0]  c_acc;
    logic [POS_W-1:0]  c_pos, c_dend, dend_new;
    logic              emit;

    // Status for the controller, from the captured beat, the radix and base registers and the result register
    assign cur_base = r_first ? r_radix : r_base;
    assign dig      = digit_of(r_char);

    always_comb begin
        o_st           = '0;
        o_st.first     = r_first;
        o_st.blank     = (r_char == CH_SPACE) || (r_char >= CH_TAB && r_char <= CH_CR);
        o_st.sign      = (r_char == CH_PLUS) || (r_char == CH_MINUS);
        o_st.minus     = (r_char == CH_MINUS);
        o_st.zero_char = (r_char == CH_0);
        o_st.x_char    = (r_char == CH_LX) || (r_char == CH_UX);
        o_st.radix_bad = (r_radix == 6'd1) || (r_radix > RADIX_MAX);
        o_st.base0     = (cur_base == '0);
        o_st.base16    = (cur_base == BASE_HEX);
        o_st.lt_base   = (dig < cur_base);
        o_st.lt8       = (dig < BASE_OCT);
        o_st.lt10      = (dig < BASE_DEC);
        o_st.out_full  = r_ovalid && i_out_stall;
    end

    // acc * base is formed as the beat is taken; the decode step only adds
    assign base_m = (r_base < BASE_MIN) ? BASE_MIN : r_base;
    assign n_prod = PROD_W'(r_acc) * PROD_W'(base_m);

    assign c_neg  = i_cmd.clear ? 1'b0 : r_neg;
    assign c_acc  = i_cmd.clear ? '0 : r_acc;
    assign c_saw  = i_cmd.clear ? 1'b0 : r_saw;
    assign c_ovf  = i_cmd.clear ? 1'b0 : r_ovf;
    assign c_pos  = i_cmd.clear ? '0 : r_pos;
    assign c_dend = i_cmd.clear ? '0 : r_dend;

    assign prod_use = i_cmd.clear ? '0 : r_prod;
    assign sum      = prod_use + PROD_W'(dig);
    assign hit      = sum > (c_neg ? LIM_NEG : LIM_POS);
    assign dend_new = (c_pos >= POS_CAP) ? POS_CAP : c_pos + 1'b1;

    always_comb begin
        n_neg  = c_neg | i_cmd.set_neg;
        n_base = r_base;
        if (i_cmd.clear)      n_base = '0;
        if (i_cmd.load_radix) n_base = r_radix;
        if (i_cmd.set_b10)    n_base = BASE_DEC;
        if (i_cmd.set_b8)     n_base = BASE_OCT;
        if (i_cmd.set_b16)    n_base = BASE_HEX;
        n_acc = c_acc;
        if (i_cmd.take && !c_ovf && !hit) begin
            n_acc = sum[ACC_W-1:0];
        end
        n_ovf  = c_ovf | (i_cmd.take & hit);
        n_saw  = c_saw | i_cmd.take | i_cmd.mark_zero;
        n_dend = (i_cmd.take || i_cmd.mark_zero) ? dend_new : c_dend;
        n_pos  = (i_cmd.advance && c_pos < POS_CAP) ? c_pos + 1'b1 : c_pos;
    end

    // Result formed from the string state as it stands before this byte
    assign emit = i_cmd.finish || i_cmd.bad_base;

    always_comb begin
        n_value = '0;
        if (c_saw) begin
            if (c_ovf) begin
                n_value = c_neg ? VALUE_MIN : VALUE_MAX;
            end else begin
                n_value = c_neg ? (~c_acc + 1'b1) : c_acc;
            end
        end
        if (i_cmd.bad_base) begin
            n_status = ST_BAD_BASE;
        end else if (c_ovf) begin
            n_status = ST_RANGE;
        end else begin
            n_status = ST_OK;
        end
        n_end = c_saw ? c_dend : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RADIX_RESET;
            r_first  <= 1'b0;
            r_neg    <= 1'b0;
            r_acc    <= '0;
            r_base   <= '0;
            r_saw    <= 1'b0;
            r_ovf    <= 1'b0;
            r_pos    <= '0;
            r_dend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_radix <= i_cfg_wr_data;
            end
            if (i_cmd.capture) begin
                r_first <= i_first_char;
            end
            r_neg  <= n_neg;
            r_acc  <= n_acc;
            r_base <= n_base;
            r_saw  <= n_saw;
            r_ovf  <= n_ovf;
            r_pos  <= n_pos;
            r_dend <= n_dend;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_char <= i_char_code;
            r_prod <= n_prod;
        end
        if (emit) begin
            r_value  <= n_value;
            r_status <= n_status;
            r_end    <= n_end;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_value      = $signed(r_value);
    assign o_status     = r_status;
    assign o_end_offset = r_end;

endmodule

>>> hdl/text_to_signed_integer_parser.sv
// Streaming text-to-signed-integer parser, top level.
// Depends on ttsip_pkg, ttsip_ctrl and ttsip_dp.
//
// Takes one character per beat (first_char opens a string) and gives one result,
// on the character that ends the number: the value, saturated to the 64-bit
// signed limits on overflow, a status (ok, out of range, invalid base) and the
// end offset. Each character goes through two steps: capture, while the
// 64x6 multiplier forms accumulator times base, then the digit add, the limit
// compare and the phase decode. The result sits in an output register; further
// characters are taken while it waits, and only the decode of a character that
// would produce the next result holds until the register is free. The radix
// register is sampled on each first character. There is no clearing pass.
module text_to_signed_integer_parser import ttsip_pkg::*; #(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [BASE_W-1:0]       i_cfg_wr_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_first_char,
    input  logic [7:0]              i_char_code,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [ACC_W-1:0] o_value,
    output logic [1:0]              o_status,
    output logic [POS_W-1:0]        o_end_offset
);

    t_dp_cmd    cmd;
    t_dp_status st;

    ttsip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    ttsip_dp #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_first_char  (i_first_char),
        .i_char_code   (i_char_code),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_value       (o_value),
        .o_status      (o_status),
        .o_end_offset  (o_end_offset)
    );

    // A result is never written over one that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.finish || cmd.bad_base) |-> !st.out_full)
        else $error("result register overwritten while held");

    // Every accepted beat is followed by its decode cycle
    a_two_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("beat accepted without decode step");

    a_bad_base_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_BAD_BASE) |-> (o_value == '0 && o_end_offset == '0))
        else $error("invalid-base result carries data");

    a_range_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_RANGE) |->
            (o_value == $signed(VALUE_MAX) || o_value == $signed(VALUE_MIN)))
        else $error("out-of-range result not saturated");

endmodule

>>> tb/tb.sv
// Self-checking bench for text_to_signed_integer_parser: directed table, then random strings.
// Predicts each conversion in a local scanner model and compares every output beat.
// Needs ttsip_pkg and the parser RTL only.
`timescale 1ns / 100ps

module tb import ttsip_pkg::*;;

    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 52;
    localparam int N_PHASES     = 10;
    localparam int SETTLE       = 12;
    localparam int N_DIR        = 32;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [POS_W-1:0] POS_CAP =
        POS_W'((MAX_CHARS_DEF > POS_LIMIT) ? POS_LIMIT : MAX_CHARS_DEF);

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_LEAD, SCAN_SIGN, SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS
    } t_scan;

    typedef enum bit {ROW_BEAT, ROW_RADIX} t_row_kind;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        t_status          status;
        logic [POS_W-1:0] end_offset;
    } t_conv;

    typedef struct {
        t_row_kind         kind;
        bit                first;
        logic [7:0]        code;
        logic [BASE_W-1:0] rdx;
        bit                typed;
        t_conv             want;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [BASE_W-1:0]       i_cfg_wr_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_first_char = 1'b0;
    logic [7:0]              i_char_code = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [ACC_W-1:0] o_value;
    logic [1:0]              o_status;
    logic [POS_W-1:0]        o_end_offset;

    // scanner model state
    logic [BASE_W-1:0] radix_q;
    t_scan             scan_st;
    logic              neg_q;
    logic [ACC_W-1:0]  acc_q;
    logic [BASE_W-1:0] base_q;
    logic              saw_q;
    logic              ovf_q;
    logic [POS_W-1:0]  pos_q;
    logic [POS_W-1:0]  dend_q;

    t_conv      pending_conv [$];
    logic [7:0] text_q [$];
    int         fault_count = 0;
    bit         steady = 1'b0;
    bit         hold_req = 1'b0;
    t_row       dir_rows [N_DIR];

    text_to_signed_integer_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_first_char  (i_first_char),
        .i_char_code   (i_char_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value       (o_value),
        .o_status      (o_status),
        .o_end_offset  (o_end_offset)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void clear_scan();
        scan_st = SCAN_IDLE;
        neg_q   = 1'b0;
        acc_q   = '0;
        base_q  = '0;
        saw_q   = 1'b0;
        ovf_q   = 1'b0;
        pos_q   = '0;
        dend_q  = '0;
    endfunction

    function automatic logic [BASE_W-1:0] char_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return BASE_W'(c - CH_0);
        if (c >= CH_LA && c <= CH_LZ) return BASE_W'(c - CH_LA + 8'd10);
        if (c >= CH_UA && c <= CH_UZ) return BASE_W'(c - CH_UA + 8'd10);
        return RADIX_MAX;
    endfunction

    function automatic void note_digit();
        saw_q  = 1'b1;
        dend_q = (pos_q >= POS_CAP) ? POS_CAP : pos_q + 1'b1;
    endfunction

    // Advances the scanner by one accepted beat; returns 1 when a conversion completes.
    function automatic bit scan_char(input bit first, input logic [7:0] c, output t_conv r);
        logic [BASE_W-1:0] d;
        logic [ACC_W-1:0]  lim;
        logic [ACC_W-1:0]  b;
        bit                skip;
        bit                emit;
        r    = '0;
        skip = 1'b0;
        emit = 1'b0;
        d    = char_value(c);
        if (first) begin
            clear_scan();
            if (radix_q == 6'd1 || radix_q > RADIX_MAX) begin
                r.status = ST_BAD_BASE;
                return 1'b1;
            end
            base_q  = radix_q;
            scan_st = SCAN_LEAD;
        end else if (scan_st == SCAN_IDLE) begin
            return 1'b0;
        end

        if (scan_st == SCAN_LEAD) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                skip = 1'b1;
            end else if (c == CH_MINUS || c == CH_PLUS) begin
                neg_q   = (c == CH_MINUS);
                scan_st = SCAN_SIGN;
                skip    = 1'b1;
            end else begin
                scan_st = SCAN_SIGN;
            end
        end

        if (!skip) begin
            if (scan_st == SCAN_SIGN) begin
                // a leading zero may open a hex prefix, so it counts as a digit already
                if (c == CH_0 && (base_q == '0 || base_q == BASE_HEX)) begin
                    acc_q = '0;
                    note_digit();
                    scan_st = SCAN_ZERO;
                    skip    = 1'b1;
                end else begin
                    if (base_q == '0) base_q = BASE_DEC;
                    scan_st = SCAN_DIGITS;
                end
            end else if (scan_st == SCAN_ZERO) begin
                if (c == CH_LX || c == CH_UX) begin
                    base_q  = BASE_HEX;
                    scan_st = SCAN_PREFIX;
                    skip    = 1'b1;
                end else begin
                    if (base_q == '0) base_q = BASE_OCT;
                    scan_st = SCAN_DIGITS;
                end
            end else if (scan_st == SCAN_PREFIX) begin
                scan_st = SCAN_DIGITS;
            end
        end

        if (!skip) begin
            if (d < base_q) begin
                if (!ovf_q) begin
                    lim = neg_q ? VALUE_MIN : VALUE_MAX;
                    b   = (base_q < BASE_MIN) ? ACC_W'(BASE_MIN) : ACC_W'(base_q);
                    if (acc_q > (lim - ACC_W'(d)) / b) ovf_q = 1'b1;
                    else acc_q = acc_q * b + ACC_W'(d);
                end
                note_digit();
            end else begin
                if (!saw_q) r.value = '0;
                else if (ovf_q) r.value = neg_q ? VALUE_MIN : VALUE_MAX;
                else r.value = neg_q ? (~acc_q + 1'b1) : acc_q;
                r.status     = ovf_q ? ST_RANGE : ST_OK;
                r.end_offset = saw_q ? dend_q : '0;
                scan_st      = SCAN_IDLE;
                emit         = 1'b1;
            end
        end

        if (pos_q < POS_CAP) pos_q = pos_q + 1'b1;
        return emit;
    endfunction

    // Mostly short gaps, now and then a long one; none in steady stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return CH_0 + 8'(d);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10);
    endfunction

    // Fills text_q with one string, mostly a well-formed number for this radix.
    function automatic void build_text(input logic [BASE_W-1:0] rdx);
        int    kind;
        int    n;
        int    r;
        int    dbase;
        string lim;
        text_q.delete();
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3))
                text_q.push_back($urandom_range(0, 1) ? CH_SPACE
                                                      : 8'($urandom_range(CH_TAB, CH_CR)));
        end
        case ($urandom_range(0, 3))
            0: text_q.push_back(CH_MINUS);
            1: text_q.push_back(CH_PLUS);
            default: ;
        endcase
        if (kind < 8 && rdx == BASE_DEC) begin
            case ($urandom_range(0, 3))
                0: lim = "9223372036854775807";
                1: lim = "9223372036854775808";
                2: lim = "9223372036854775806";
                default: lim = "18446744073709551616";
            endcase
            for (int i = 0; i < lim.len(); i++) text_q.push_back(lim[i]);
        end else begin
            dbase = (rdx == 6'd1 || rdx > RADIX_MAX) ? 10 : int'(rdx);
            if ((rdx == '0 || rdx == BASE_HEX) && $urandom_range(0, 2) == 0) begin
                text_q.push_back(CH_0);
                text_q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                dbase = 16;
            end else if (rdx == '0) begin
                dbase = 10;
                if ($urandom_range(0, 1)) begin
                    text_q.push_back(CH_0);
                    dbase = 8;
                end
            end
            // broken strings: sign or prefix with nothing after it
            if (kind < 16) begin
                n = 0;
            end else begin
                r = $urandom_range(0, 99);
                n = (r < 65) ? $urandom_range(1, 6)
                  : (r < 88) ? $urandom_range(7, 18) : $urandom_range(19, 66);
            end
            repeat (n) text_q.push_back(digit_char($urandom_range(0, dbase - 1)));
        end
        // a few strings are left open and abandoned by the next first beat
        if (kind < 95) begin
            r = $urandom_range(0, 99);
            if (r < 30) text_q.push_back(CH_NUL);
            else if (r < 45) text_q.push_back(CH_SPACE);
            else if (r < 60) text_q.push_back(8'($urandom_range(128, 255)));
            else text_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_beat(input bit first, input logic [7:0] code,
                             input bit typed, input t_conv want);
        t_conv got;
        int    g;
        i_in_valid   <= 1'b1;
        i_first_char <= first;
        i_char_code  <= code;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (scan_char(first, code, got)) pending_conv.push_back(typed ? want : got);
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Wait for every expected result, then let any beat still inside the block finish.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending_conv.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [BASE_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        radix_q = v;
    endtask

    always @(posedge i_clk) begin
        t_conv want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_conv.size() == 0) begin
                $error("unexpected result: value %0d status %0d end_offset %0d",
                       o_value, o_status, o_end_offset);
                fault_count++;
            end else begin
                want = pending_conv.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %0d, got %0d", $signed(want.value), o_value);
                    fault_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fault_count++;
                end
                if (o_end_offset !== want.end_offset) begin
                    $error("end_offset: expected %0d, got %0d", want.end_offset, o_end_offset);
                    fault_count++;
                end
            end
        end
    end

    // Receiver side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        logic [BASE_W-1:0] phase_radix [N_PHASES];
        logic [BASE_W-1:0] rdx;
        int                items;
        int                n_extra;
        phase_radix = '{6'd10, 6'd0, 6'd16, 6'd2, 6'd36, 6'd8, 6'd47, 6'd0, 6'd21, 6'd10};
        dir_rows = '{
            '{ROW_BEAT,  1'b0, "5",    6'd0,  1'b0, '0},    // byte while idle
            '{ROW_BEAT,  1'b1, "7",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, 8'hFF,  6'd0,  1'b1, '{64'd7, ST_OK, 13'd1}},
            '{ROW_BEAT,  1'b1, CH_NUL, 6'd0,  1'b1, '{64'd0, ST_OK, 13'd0}},
            '{ROW_BEAT,  1'b1, CH_TAB, 6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, "-",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, "4",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, "2",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, CH_CR,  6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b1, "-",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, "4",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b1, "3",    6'd0,  1'b0, '0},    // restart mid-string
            '{ROW_BEAT,  1'b0, CH_NUL, 6'd0,  1'b0, '0},
            '{ROW_RADIX, 1'b0, CH_NUL, 6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b1, "0",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, "x",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, "g",    6'd0,  1'b1, '{64'd0, ST_OK, 13'd1}},
            '{ROW_BEAT,  1'b1, "0",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, "X",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, "f",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, CH_NUL, 6'd0,  1'b0, '0},
            '{ROW_RADIX, 1'b0, CH_NUL, 6'd1,  1'b0, '0},
            '{ROW_BEAT,  1'b1, "5",    6'd0,  1'b1, '{64'd0, ST_BAD_BASE, 13'd0}},
            '{ROW_RADIX, 1'b0, CH_NUL, 6'd63, 1'b0, '0},
            '{ROW_BEAT,  1'b1, "5",    6'd0,  1'b1, '{64'd0, ST_BAD_BASE, 13'd0}},
            '{ROW_RADIX, 1'b0, CH_NUL, 6'd36, 1'b0, '0},
            '{ROW_BEAT,  1'b1, "Z",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, "z",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, " ",    6'd0,  1'b0, '0},
            '{ROW_RADIX, 1'b0, CH_NUL, 6'd2,  1'b0, '0},
            '{ROW_BEAT,  1'b1, "1",    6'd0,  1'b0, '0},
            '{ROW_BEAT,  1'b0, "2",    6'd0,  1'b0, '0}
        };

        clear_scan();
        radix_q = RADIX_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_RADIX) begin
                drain_block();
                write_radix(dir_rows[k].rdx);
            end else begin
                send_beat(dir_rows[k].first, dir_rows[k].code,
                          dir_rows[k].typed, dir_rows[k].want);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            rdx = (p == 8) ? BASE_W'($urandom_range(0, 63)) : phase_radix[p];
            drain_block();
            write_radix(rdx);
            steady = (p == 3);
            if (p == 2) hold_req = 1'b1;
            items = 0;
            while (items < PHASE_ITEMS) begin
                build_text(rdx);
                foreach (text_q[i]) send_beat(i == 0, text_q[i], 1'b0, '0);
                items += text_q.size();
                if ($urandom_range(0, 9) == 0) begin
                    n_extra = $urandom_range(1, 3);
                    repeat (n_extra) send_beat(1'b0, 8'($urandom), 1'b0, '0);
                    items += n_extra;
                end
            end
        end

        drain_block();

        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
